// ----- rtl/core/bprd_pkg.sv -----
// ----------------------------------------------------------------------------
// bprd_pkg
// Shared types, codes and helpers of the bit-pack / Rice block decoder.
// ----------------------------------------------------------------------------
package bprd_pkg;

   localparam int BLOCK_SAMPLES = 64;
   localparam int IDX_W         = $clog2(BLOCK_SAMPLES);
   localparam int CNT_W         = IDX_W + 1;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_BAD_MODE = 3'd1;
   localparam logic [2:0] ERR_QUOT     = 3'd2;
   localparam logic [2:0] ERR_VALUE    = 3'd3;
   localparam logic [2:0] ERR_NO_BLOCK = 3'd4;

   localparam logic [3:0] MODE_ZERO   = 4'd0;
   localparam logic [3:0] MODE_SPARSE = 4'd9;

   localparam logic REQ_HEADER = 1'b0;

   typedef enum logic [7:0] {
      OP_NONE  = 8'b0000_0001,
      OP_LOAD  = 8'b0000_0010,
      OP_START = 8'b0000_0100,
      OP_ZERO  = 8'b0000_1000,
      OP_PACK  = 8'b0001_0000,
      OP_FILL  = 8'b0010_0000,
      OP_RICE  = 8'b0100_0000,
      OP_FLUSH = 8'b1000_0000
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic item_hdr;
      logic item_zero_ok;
      logic open;
      logic pack_mode;
      logic sparse_mode;
      logic fill_after;
      logic pack_ready;
      logic fill_ready;
      logic rice_ready;
      logic out_free;
   } status_type;

   function automatic logic [7:0] unzig8(input logic [7:0] z);
      unzig8 = {1'b0, z[7:1]} ^ {8{z[0]}};
   endfunction

endpackage

// ----- rtl/core/bprd_ctrl.sv -----
// ----------------------------------------------------------------------------
// bprd_ctrl
// Sequencer: takes one request, steps the datapath, flushes the last result.
// ----------------------------------------------------------------------------
module bprd_ctrl
   import bprd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b000_0001,
      ST_START = 7'b000_0010,
      ST_ZERO  = 7'b000_0100,
      ST_PACK  = 7'b000_1000,
      ST_FILL  = 7'b001_0000,
      ST_RICE  = 7'b010_0000,
      ST_FLUSH = 7'b100_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.out_free) begin
               cmd.op = OP_START;
               if (status.item_hdr) begin
                  state_in = status.item_zero_ok ? ST_ZERO : ST_FLUSH;
               end else if (!status.open) begin
                  state_in = ST_FLUSH;
               end else if (status.pack_mode) begin
                  state_in = ST_PACK;
               end else if (status.sparse_mode) begin
                  state_in = status.fill_after ? ST_FILL : ST_FLUSH;
               end else begin
                  state_in = ST_RICE;
               end
            end
         end
         ST_ZERO: begin
            if (!status.open) state_in = ST_FLUSH;
            else if (status.out_free) cmd.op = OP_ZERO;
         end
         ST_PACK: begin
            if (!status.pack_ready) state_in = ST_FLUSH;
            else if (status.out_free) cmd.op = OP_PACK;
         end
         ST_FILL: begin
            if (!status.fill_ready) state_in = ST_FLUSH;
            else if (status.out_free) cmd.op = OP_FILL;
         end
         ST_RICE: begin
            if (!status.rice_ready) state_in = ST_FLUSH;
            else if (status.out_free) cmd.op = OP_RICE;
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.op   = OP_FLUSH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- rtl/core/bprd_dpath.sv -----
// ----------------------------------------------------------------------------
// bprd_dpath
// Block state, one decode step per command, pending and output result regs.
// ----------------------------------------------------------------------------
module bprd_dpath
   import bprd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  logic             req_type,
   input  logic [3:0]       req_block_mode,
   input  logic             req_delta_on,
   input  logic [6:0]       req_valid_count,
   input  logic [7:0]       req_data_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_sample,
   output logic [IDX_W-1:0] rsp_sample_index,
   output logic             rsp_last_of_run,
   output logic             rsp_block_done,
   output logic [2:0]       rsp_error_code
);

   logic             item_type_ff, item_type_in;
   logic [3:0]       item_mode_ff, item_mode_in;
   logic             item_delta_ff, item_delta_in;
   logic [6:0]       item_cnt_ff, item_cnt_in;
   logic [7:0]       item_byte_ff, item_byte_in;

   logic             rice_en_ff;
   logic             open_ff, open_in;
   logic [3:0]       mode_ff, mode_in;
   logic             delta_ff, delta_in;
   logic [CNT_W-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0] nidx_ff, nidx_in;
   logic [15:0]      accum_ff, accum_in;
   logic [4:0]       count_ff, count_in;
   logic [63:0]      mask_ff, mask_in;
   logic [3:0]       seen_ff, seen_in;
   logic [8:0]       quot_ff, quot_in;
   logic             phase_ff, phase_in;
   logic [4:0]       rem_ff, rem_in;
   logic [2:0]       rbits_ff, rbits_in;
   logic [7:0]       dsum_ff, dsum_in;
   logic [3:0]       bit_ff, bit_in;

   logic             pend_valid_ff;
   logic [7:0]       pend_sample_ff;
   logic [IDX_W-1:0] pend_index_ff;
   logic             pend_done_ff;
   logic [2:0]       pend_err_ff;

   logic             res_v;
   logic [7:0]       res_sample;
   logic [IDX_W-1:0] res_index;
   logic             res_done;
   logic [2:0]       res_err;

   logic             emit_go, fail_go, clear_go, finish, cur_bit, push_go, hdr_ok;
   logic [7:0]       emit_val, s_val, wmask;
   logic [2:0]       fail_code, rk, rbits_new;
   logic [8:0]       quot_new;
   logic [4:0]       rem_new;
   logic [13:0]      zval;

   assign hdr_ok = !((item_mode_ff > MODE_SPARSE) && !rice_en_ff);
   assign rk     = mode_ff[2:0] - 3'd2;

   assign status.item_hdr     = (item_type_ff == REQ_HEADER);
   assign status.item_zero_ok = hdr_ok && (item_mode_ff == MODE_ZERO);
   assign status.open         = open_ff;
   assign status.pack_mode    = (mode_ff != MODE_ZERO) && (mode_ff < MODE_SPARSE);
   assign status.sparse_mode  = (mode_ff == MODE_SPARSE);
   assign status.fill_after   = (seen_ff >= 4'd7);
   assign status.pack_ready   = open_ff && (count_ff >= {1'b0, mode_ff});
   assign status.fill_ready   = open_ff && !mask_ff[nidx_ff[IDX_W-1:0]];
   assign status.rice_ready   = open_ff && !bit_ff[3];
   assign status.out_free     = !rsp_valid || !rsp_stall;

   always_comb begin
      item_type_in  = item_type_ff;
      item_mode_in  = item_mode_ff;
      item_delta_in = item_delta_ff;
      item_cnt_in   = item_cnt_ff;
      item_byte_in  = item_byte_ff;
      open_in   = open_ff;
      mode_in   = mode_ff;
      delta_in  = delta_ff;
      valid_in  = valid_ff;
      nidx_in   = nidx_ff;
      accum_in  = accum_ff;
      count_in  = count_ff;
      mask_in   = mask_ff;
      seen_in   = seen_ff;
      quot_in   = quot_ff;
      phase_in  = phase_ff;
      rem_in    = rem_ff;
      rbits_in  = rbits_ff;
      dsum_in   = dsum_ff;
      bit_in    = bit_ff;
      res_v      = 1'b0;
      res_sample = '0;
      res_index  = '0;
      res_done   = 1'b0;
      res_err    = ERR_NONE;
      emit_go   = 1'b0;
      emit_val  = '0;
      fail_go   = 1'b0;
      fail_code = ERR_NONE;
      clear_go  = 1'b0;
      finish    = 1'b0;
      cur_bit   = item_byte_ff[bit_ff[2:0]];
      wmask     = 8'hFF >> (4'd8 - mode_ff);
      quot_new  = quot_ff + 9'd1;
      rem_new   = rem_ff;
      rbits_new = rbits_ff;
      zval      = '0;
      s_val     = '0;

      unique case (cmd.op)
         OP_LOAD: begin
            item_type_in  = req_type;
            item_mode_in  = req_block_mode;
            item_delta_in = req_delta_on;
            item_cnt_in   = req_valid_count;
            item_byte_in  = req_data_byte;
         end
         OP_START: begin
            if (item_type_ff == REQ_HEADER) begin
               clear_go = 1'b1;
               open_in  = hdr_ok;
               if (!hdr_ok) begin
                  res_v    = 1'b1;
                  res_done = 1'b1;
                  res_err  = ERR_BAD_MODE;
               end else begin
                  mode_in  = item_mode_ff;
                  delta_in = item_delta_ff;
                  valid_in = (item_cnt_ff > CNT_W'(BLOCK_SAMPLES)) ?
                             CNT_W'(BLOCK_SAMPLES) : item_cnt_ff;
               end
            end else if (!open_ff) begin
               res_v    = 1'b1;
               res_done = 1'b1;
               res_err  = ERR_NO_BLOCK;
            end else if (status.pack_mode) begin
               accum_in = accum_ff | ({8'h00, item_byte_ff} << count_ff[3:0]);
               count_in = count_ff + 5'd8;
            end else if (status.sparse_mode) begin
               if (!seen_ff[3]) begin
                  mask_in[seen_ff[2:0]*8 +: 8] = item_byte_ff;
                  seen_in = seen_ff + 4'd1;
               end else begin
                  emit_go  = 1'b1;
                  emit_val = unzig8(item_byte_ff);
               end
            end else begin
               bit_in = '0;
            end
         end
         OP_ZERO, OP_FILL: begin
            emit_go = 1'b1;
         end
         OP_PACK: begin
            emit_go  = 1'b1;
            emit_val = unzig8(accum_ff[7:0] & wmask);
            accum_in = accum_ff >> mode_ff;
            count_in = count_ff - {1'b0, mode_ff};
         end
         OP_RICE: begin
            bit_in = bit_ff + 4'd1;
            if (!phase_ff) begin
               if (!cur_bit) begin
                  if (quot_new > 9'd255) begin
                     fail_go   = 1'b1;
                     fail_code = ERR_QUOT;
                  end else begin
                     quot_in = quot_new;
                  end
               end else if (rk == 3'd0) begin
                  finish = 1'b1;
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               rem_new   = rem_ff | (5'(cur_bit) << rbits_ff);
               rbits_new = rbits_ff + 3'd1;
               rem_in    = rem_new;
               rbits_in  = rbits_new;
               finish    = (rbits_new >= rk);
            end
            if (finish) begin
               zval = ({5'd0, quot_ff} << rk) | {9'd0, rem_new};
               if (zval > 14'd255) begin
                  fail_go   = 1'b1;
                  fail_code = ERR_VALUE;
               end else begin
                  quot_in  = '0;
                  phase_in = 1'b0;
                  rem_in   = '0;
                  rbits_in = '0;
                  emit_go  = 1'b1;
                  emit_val = unzig8(zval[7:0]);
               end
            end
         end
         default: begin
         end
      endcase

      if (emit_go) begin
         s_val   = delta_ff ? (dsum_ff + emit_val) : emit_val;
         dsum_in = delta_ff ? s_val : dsum_ff;
         nidx_in = nidx_ff + 1'b1;
         if (nidx_ff < valid_ff) begin
            res_v      = 1'b1;
            res_sample = s_val;
            res_index  = nidx_ff[IDX_W-1:0];
            res_done   = (nidx_in == CNT_W'(BLOCK_SAMPLES));
         end else if (nidx_in == CNT_W'(BLOCK_SAMPLES)) begin
            res_v     = 1'b1;
            res_index = IDX_W'(BLOCK_SAMPLES - 1);
            res_done  = 1'b1;
         end
         if (nidx_in == CNT_W'(BLOCK_SAMPLES)) begin
            open_in  = 1'b0;
            clear_go = 1'b1;
         end
      end

      if (fail_go) begin
         res_v     = 1'b1;
         res_index = nidx_ff[IDX_W-1:0];
         res_done  = 1'b1;
         res_err   = fail_code;
         open_in   = 1'b0;
         clear_go  = 1'b1;
      end

      if (clear_go) begin
         nidx_in  = '0;
         accum_in = '0;
         count_in = '0;
         mask_in  = '0;
         seen_in  = '0;
         quot_in  = '0;
         phase_in = 1'b0;
         rem_in   = '0;
         rbits_in = '0;
         dsum_in  = '0;
      end
   end

   assign push_go = pend_valid_ff && (res_v || (cmd.op == OP_FLUSH));

   always_ff @(posedge clock) begin
      if (reset) begin
         rice_en_ff    <= 1'b1;
         open_ff       <= 1'b0;
         mode_ff       <= '0;
         delta_ff      <= 1'b0;
         valid_ff      <= '0;
         nidx_ff       <= '0;
         accum_ff      <= '0;
         count_ff      <= '0;
         mask_ff       <= '0;
         seen_ff       <= '0;
         quot_ff       <= '0;
         phase_ff      <= 1'b0;
         rem_ff        <= '0;
         rbits_ff      <= '0;
         dsum_ff       <= '0;
         bit_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid     <= 1'b0;
      end else begin
         if (csr_wr_en) rice_en_ff <= csr_wr_data;
         open_ff  <= open_in;
         mode_ff  <= mode_in;
         delta_ff <= delta_in;
         valid_ff <= valid_in;
         nidx_ff  <= nidx_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
         mask_ff  <= mask_in;
         seen_ff  <= seen_in;
         quot_ff  <= quot_in;
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         rbits_ff <= rbits_in;
         dsum_ff  <= dsum_in;
         bit_ff   <= bit_in;
         if (res_v)                     pend_valid_ff <= 1'b1;
         else if (cmd.op == OP_FLUSH)   pend_valid_ff <= 1'b0;
         if (push_go)                   rsp_valid <= 1'b1;
         else if (!rsp_stall)           rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_type_ff  <= item_type_in;
      item_mode_ff  <= item_mode_in;
      item_delta_ff <= item_delta_in;
      item_cnt_ff   <= item_cnt_in;
      item_byte_ff  <= item_byte_in;
      if (res_v) begin
         pend_sample_ff <= res_sample;
         pend_index_ff  <= res_index;
         pend_done_ff   <= res_done;
         pend_err_ff    <= res_err;
      end
      if (push_go) begin
         rsp_sample       <= pend_sample_ff;
         rsp_sample_index <= pend_index_ff;
         rsp_block_done   <= pend_done_ff;
         rsp_error_code   <= pend_err_ff;
         rsp_last_of_run  <= (cmd.op == OP_FLUSH);
      end
   end

   a_closed_clean: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> (nidx_ff == '0) && (count_ff == '0) && (seen_ff == '0))
      else $error("closed block holds stale decode state");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (quot_ff <= 9'd255) && (nidx_ff < CNT_W'(BLOCK_SAMPLES)))
      else $error("quotient or index out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !push_go)
      else $error("result pushed over a stalled result");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FLUSH) |=> !pend_valid_ff)
      else $error("pending result survives flush");

endmodule

// ----- rtl/core/block_bitpack_rice_decoder.sv -----
// ----------------------------------------------------------------------------
// block_bitpack_rice_decoder
// Residual block decoder: zero, bit-pack, sparse and Rice modes, delta sum.
//
//   channel  | ports                                       | direction
//   ---------+---------------------------------------------+----------
//   request  | req_valid/req_stall, req_type .. data_byte  | in
//   response | rsp_valid/rsp_stall, rsp_sample .. error    | out
//   csr      | csr_wr_en, csr_wr_data (rice_enable)        | in
//
// One request at a time: the accept loads it, then a start step, the decode
// steps (one per emitted code, Rice bit or zero fill; one per cycle while the
// response is not stalled), a step to leave the step state and a flush.
// Response stall holds the step sequencer.
// Synchronous reset clears block state; rice_enable resets to 1.
// ----------------------------------------------------------------------------
module block_bitpack_rice_decoder
   import bprd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_type,
   input  logic [3:0]       req_block_mode,
   input  logic             req_delta_on,
   input  logic [6:0]       req_valid_count,
   input  logic [7:0]       req_data_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_sample,
   output logic [IDX_W-1:0] rsp_sample_index,
   output logic             rsp_last_of_run,
   output logic             rsp_block_done,
   output logic [2:0]       rsp_error_code
);

   cmd_type    cmd;
   status_type status;

   bprd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bprd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_type         (req_type),
      .req_block_mode   (req_block_mode),
      .req_delta_on     (req_delta_on),
      .req_valid_count  (req_valid_count),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_sample_index (rsp_sample_index),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_block_done   (rsp_block_done),
      .rsp_error_code   (rsp_error_code)
   );

endmodule

// ----- sim/bprd_checker.sv -----
// ----------------------------------------------------------------------------
// bprd_checker
// Watches the request and response channels of the block decoder, predicts
// every response from each accepted request and compares field by field.
// ----------------------------------------------------------------------------
module bprd_checker
   import bprd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_type,
   input  logic [3:0] req_block_mode,
   input  logic       req_delta_on,
   input  logic [6:0] req_valid_count,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_sample,
   input  logic [5:0] rsp_sample_index,
   input  logic       rsp_last_of_run,
   input  logic       rsp_block_done,
   input  logic [2:0] rsp_error_code,
   output int         fail_count,
   output int         pending_count
);

   typedef struct packed {
      logic [7:0] sample;
      logic [5:0] index;
      logic       last;
      logic       done;
      logic [2:0] err;
   } sample_rec;

   sample_rec  sample_q[$];
   sample_rec  run_q[$];
   logic       rice_en;
   logic       is_open;
   logic [3:0] mode;
   logic       delta;
   logic [6:0] vcount;
   int         nidx;
   int         acc;
   int         acc_n;
   logic [63:0] mask;
   int         mask_n;
   int         quot;
   logic       phase;
   int         rem;
   int         rem_n;
   logic [7:0] dsum;

   assign pending_count = sample_q.size();

   function automatic logic [7:0] zz_decode(input int z);
      logic [7:0] b;
      b = z[7:0];
      return {1'b0, b[7:1]} ^ {8{b[0]}};
   endfunction

   task automatic add_rec(input logic [7:0] s, input int idx, input logic dn,
                          input logic [2:0] e);
      sample_rec r;
      r.sample = s;
      r.index = idx[5:0];
      r.last = 1'b0;
      r.done = dn;
      r.err = e;
      run_q = {run_q, r};
   endtask

   task automatic clear_block();
      nidx = 0; acc = 0; acc_n = 0; mask = '0; mask_n = 0;
      quot = 0; phase = 0; rem = 0; rem_n = 0; dsum = 0;
   endtask

   task automatic put_value(input logic [7:0] v);
      logic [7:0] s;
      int idx;
      logic dn;
      s = v;
      idx = nidx;
      if (delta) begin
         dsum = dsum + v;
         s = dsum;
      end
      nidx = idx + 1;
      dn = nidx >= BLOCK_SAMPLES;
      if (idx < vcount) add_rec(s, idx, dn, ERR_NONE);
      else if (dn) add_rec(8'd0, BLOCK_SAMPLES - 1, 1'b1, ERR_NONE);
      if (dn) begin
         is_open = 0;
         clear_block();
      end
   endtask

   task automatic fail_block(input int idx, input logic [2:0] e);
      add_rec(8'd0, idx, 1'b1, e);
      is_open = 0;
      clear_block();
   endtask

   task automatic fill_sparse();
      while (is_open && !mask[nidx[5:0]]) put_value(8'd0);
   endtask

   task automatic decode_rice(input logic [7:0] by);
      int k;
      int z;
      logic fin;
      k = mode - 10;
      for (int b = 0; b < 8 && is_open; b++) begin
         fin = 0;
         if (!phase) begin
            if (!by[b]) begin
               quot++;
               if (quot > 255) begin
                  fail_block(nidx, ERR_QUOT);
                  return;
               end
            end else if (k == 0) fin = 1;
            else phase = 1;
         end else begin
            rem = rem | (int'(by[b]) << rem_n);
            rem_n++;
            if (rem_n >= k) fin = 1;
         end
         if (fin) begin
            z = (quot << k) | rem;
            if (z > 255) begin
               fail_block(nidx, ERR_VALUE);
               return;
            end
            quot = 0; phase = 0; rem = 0; rem_n = 0;
            put_value(zz_decode(z));
         end
      end
   endtask

   task automatic predict_request();
      int code;
      run_q.delete();
      if (req_type == REQ_HEADER) begin
         is_open = 0;
         clear_block();
         if (req_block_mode > 4'd9 && !rice_en) begin
            add_rec(8'd0, 0, 1'b1, ERR_BAD_MODE);
         end else begin
            mode = req_block_mode;
            delta = req_delta_on;
            vcount = req_valid_count > 7'd64 ? 7'd64 : req_valid_count;
            is_open = 1;
            if (mode == MODE_ZERO) while (is_open) put_value(8'd0);
         end
      end else if (!is_open) begin
         add_rec(8'd0, 0, 1'b1, ERR_NO_BLOCK);
      end else if (mode >= 4'd1 && mode <= 4'd8) begin
         acc = (acc | (int'(req_data_byte) << acc_n)) & 16'hFFFF;
         acc_n += 8;
         while (is_open && acc_n >= mode) begin
            code = acc & ((1 << mode) - 1);
            acc = acc >> mode;
            acc_n -= mode;
            put_value(zz_decode(code));
         end
      end else if (mode == MODE_SPARSE) begin
         if (mask_n < 8) begin
            mask = mask | (64'(req_data_byte) << (8 * mask_n));
            mask_n++;
            if (mask_n == 8) fill_sparse();
         end else begin
            put_value(zz_decode(req_data_byte));
            fill_sparse();
         end
      end else begin
         decode_rice(req_data_byte);
      end
      if (run_q.size() > 0) run_q[$].last = 1'b1;
      sample_q = {sample_q, run_q};
   endtask

   task automatic report(input string what, input int got, input int want);
      $display("ERROR %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rice_en = 1;
         is_open = 0; mode = 0; delta = 0; vcount = 0;
         clear_block();
         sample_q.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) rice_en = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (sample_q.size() == 0) begin
               report("unexpected response", rsp_sample, 0);
            end else begin
               sample_rec w;
               w = sample_q[0];
               sample_q.delete(0);
               if (rsp_sample !== w.sample) report("sample", rsp_sample, w.sample);
               if (rsp_sample_index !== w.index)
                  report("sample_index", rsp_sample_index, w.index);
               if (rsp_last_of_run !== w.last)
                  report("last_of_run", rsp_last_of_run, w.last);
               if (rsp_block_done !== w.done)
                  report("block_done", rsp_block_done, w.done);
               if (rsp_error_code !== w.err)
                  report("error_code", rsp_error_code, w.err);
            end
         end
         if (req_valid && !req_stall) predict_request();
      end
   end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random requests through the block decoder with random
// gaps and response stalls; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module testbench;
   import bprd_pkg::*;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic       csr_wr_data;
   logic       req_valid;
   logic       req_stall;
   logic       req_type;
   logic [3:0] req_block_mode;
   logic       req_delta_on;
   logic [6:0] req_valid_count;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_sample;
   logic [5:0] rsp_sample_index;
   logic       rsp_last_of_run;
   logic       rsp_block_done;
   logic [2:0] rsp_error_code;
   int         fail_count;
   int         pending_count;
   int         cycle_count = 0;
   logic       long_hold;

   localparam int CYCLE_LIMIT = 600000;

   block_bitpack_rice_decoder u_dut (.*);
   bprd_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("block_bitpack_rice_decoder: mismatch");
         $finish;
      end
   end

   // response stall: random per response, plus one long hold-off
   initial begin
      int wait_n;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            wait_n = $urandom_range(0, 6);
            if (($urandom & 3) == 0) wait_n = 0;
            if (wait_n != 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_request(input logic t, input logic [3:0] m, input logic d,
                               input logic [6:0] vc, input logic [7:0] b);
      int gap;
      gap = ($urandom & 1) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= t;
      req_block_mode <= m;
      req_delta_on <= d;
      req_valid_count <= vc;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_header(input logic [3:0] m, input logic d, input logic [6:0] vc);
      send_request(REQ_HEADER, m, d, vc, 8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_request(~REQ_HEADER, 4'($urandom), 1'($urandom), 7'($urandom), b);
   endtask

   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_rice_enable(input logic v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_block(output int cnt);
      int m;
      int r;
      int n;
      m = $urandom_range(0, 15);
      r = $urandom_range(0, 9);
      send_header(m[3:0], 1'($urandom), (r < 2) ? 7'(64 + $urandom_range(0, 63)) :
                  7'($urandom_range(0, 64)));
      if (m >= 1 && m <= 8) n = (m * 64 + 7) / 8;
      else if (m == 9) n = 8 + $urandom_range(0, 12);
      else n = $urandom_range(4, 40);
      if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
      for (int i = 0; i < n; i++) begin
         if (m >= 10 && ($urandom & 1)) send_byte(8'hFF);
         else if (m == 9 && i < 8 && ($urandom & 1)) send_byte(8'($urandom & $urandom));
         else send_byte(8'($urandom));
      end
      cnt = n + 1;
   endtask

   initial begin
      int sent;
      int blk;
      long_hold = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_valid = 1'b0;
      req_type = 1'b0;
      req_block_mode = '0;
      req_delta_on = 1'b0;
      req_valid_count = '0;
      req_data_byte = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_byte(8'hA5);
      send_header(MODE_ZERO, 1'b0, 7'd64);
      send_header(MODE_ZERO, 1'b1, 7'd127);
      send_header(4'd8, 1'b1, 7'd3);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h01);
      send_header(4'd1, 1'b0, 7'd0);
      send_byte(8'hFF);
      send_header(MODE_SPARSE, 1'b0, 7'd64);
      for (int i = 0; i < 8; i++) send_byte(i == 0 ? 8'h03 : 8'h80);
      send_byte(8'hFF);
      send_byte(8'h02);
      send_header(4'd10, 1'b0, 7'd64);
      repeat (32) send_byte(8'h00);
      send_header(4'd15, 1'b1, 7'd64);
      send_byte(8'hFF);
      send_byte(8'h01);
      send_header(4'd13, 1'b0, 7'd10);
      send_byte(8'h81);
      drain_and_idle();
      write_rice_enable(1'b0);
      send_header(4'd12, 1'b0, 7'd5);
      send_header(4'd15, 1'b1, 7'd64);
      send_byte(8'h11);
      drain_and_idle();
      write_rice_enable(1'b1);

      // long response hold-off while requests keep coming
      long_hold = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         begin
            send_header(4'd4, 1'b0, 7'd64);
            repeat (32) send_byte(8'($urandom));
         end
      join

      sent = 0;
      for (int ph = 0; ph < 3; ph++) begin
         drain_and_idle();
         write_rice_enable(ph != 1);
         while (sent < 24 * (ph + 1)) begin
            if ($urandom_range(0, 9) == 0) begin
               send_byte(8'($urandom));
               sent++;
            end else begin
               random_block(blk);
               sent += blk;
            end
         end
      end

      drain_and_idle();
      if (fail_count == 0) begin
         $display("block_bitpack_rice_decoder: match");
      end else begin
         $display("block_bitpack_rice_decoder: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/bprd_pkg.sv
rtl/core/bprd_ctrl.sv
rtl/core/bprd_dpath.sv
rtl/core/block_bitpack_rice_decoder.sv
sim/bprd_checker.sv
sim/testbench.sv
